/* hdl/quaternion_to_euler_angles_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion to Euler angle converter
// Clocked on clk; the first form is gated by the asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_TOP_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define QTE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define QTE_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QTE_ASSERT(lbl, prop, msg)
`define QTE_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* hdl/qte_pkg.sv */
// ----------------------------------------------------------------------------
// qte_pkg
// Beat types, datapath widths and the arctangent table.
// ----------------------------------------------------------------------------
package qte_pkg;

	localparam int PROD_W    = 32;  // Q1.15 x Q1.15
	localparam int TERM_W    = 34;  // sine / cosine terms, 1.0 = 2^30
	localparam int CORD_W    = 37;  // CORDIC x/y with gain headroom
	localparam int ANG_W     = 34;  // angle accumulator, pi = 2^31
	localparam int MAG_W     = 30;  // |sine| of pitch when not clamped
	localparam int REM_W     = 61;  // 1 - s^2, 1.0 = 2^60
	localparam int RES_W     = 62;
	localparam int ROOT_W    = 31;
	localparam int SQ_ITERS  = 31;
	localparam int ATAN_LEN  = 24;
	localparam int TERMS_LAT = 2;
	localparam int SQRT_LAT  = SQ_ITERS + 2;

	localparam logic signed [TERM_W-1:0] ONE_Q30     = TERM_W'(1) <<< 30;
	localparam logic signed [ANG_W-1:0]  HALF_PI     = ANG_W'(1) <<< 30;
	localparam logic signed [ANG_W-1:0]  ROUND_HALF  = ANG_W'(1) <<< 15;
	localparam logic [REM_W-1:0]         REM_ONE     = REM_W'(1) << (REM_W - 1);
	localparam logic signed [15:0]       PITCH_POS   = 16'sh4000;
	localparam logic signed [15:0]       PITCH_NEG   = 16'shC000;

	// atan(2^-i), pi = 2^31
	localparam logic signed [ANG_W-1:0] ATAN_TAB [ATAN_LEN] = '{
		34'h020000000, 34'h012E4051E, 34'h009FB385B, 34'h0051111D4,
		34'h0028B0D43, 34'h00145D7E1, 34'h000A2F61E, 34'h000517C55,
		34'h00028BE53, 34'h000145F2F, 34'h0000A2F98, 34'h0000517CC,
		34'h000028BE6, 34'h0000145F3, 34'h00000A2F9, 34'h00000517C,
		34'h0000028BE, 34'h00000145F, 34'h000000A2F, 34'h000000517,
		34'h00000028B, 34'h000000145, 34'h0000000A2, 34'h000000051
	};

	typedef struct packed {
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
	} quat_beat_t;

	typedef struct packed {
		logic signed [15:0] yaw_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] roll_angle;
		logic               pitch_clamped;
	} euler_beat_t;

	typedef struct packed {
		logic signed [TERM_W-1:0] yaw_s;
		logic signed [TERM_W-1:0] yaw_c;
		logic signed [TERM_W-1:0] roll_s;
		logic signed [TERM_W-1:0] roll_c;
		logic signed [TERM_W-1:0] pitch_s;
		logic                     clamp;
		logic [MAG_W-1:0]         mag;
	} terms_t;

endpackage

/* hdl/qte_terms.sv */
// ----------------------------------------------------------------------------
// qte_terms
// Quaternion products, then sine and cosine of yaw and roll, sine of pitch.
// ----------------------------------------------------------------------------
module qte_terms import qte_pkg::*; (
	input  logic       clk,
	input  logic       en,
	input  quat_beat_t quat,
	output terms_t     terms
);

	logic signed [PROD_W-1:0] p_xy_s1, p_zw_s1, p_yy_s1, p_zz_s1, p_wy_s1;
	logic signed [PROD_W-1:0] p_xz_s1, p_wx_s1, p_yz_s1, p_xx_s1;
	logic signed [TERM_W-1:0] yaw_s, yaw_c, roll_s, roll_c, pit_s, abs_s;
	logic                     clamp;
	terms_t                   terms_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			p_xy_s1 <= quat.quat_x * quat.quat_y;
			p_zw_s1 <= quat.quat_z * quat.quat_w;
			p_yy_s1 <= quat.quat_y * quat.quat_y;
			p_zz_s1 <= quat.quat_z * quat.quat_z;
			p_wy_s1 <= quat.quat_w * quat.quat_y;
			p_xz_s1 <= quat.quat_x * quat.quat_z;
			p_wx_s1 <= quat.quat_w * quat.quat_x;
			p_yz_s1 <= quat.quat_y * quat.quat_z;
			p_xx_s1 <= quat.quat_x * quat.quat_x;
		end
	end

	assign yaw_s  = (TERM_W'(p_xy_s1) + TERM_W'(p_zw_s1)) <<< 1;
	assign yaw_c  = ONE_Q30 - ((TERM_W'(p_yy_s1) + TERM_W'(p_zz_s1)) <<< 1);
	assign pit_s  = (TERM_W'(p_wy_s1) - TERM_W'(p_xz_s1)) <<< 1;
	assign roll_s = (TERM_W'(p_wx_s1) + TERM_W'(p_yz_s1)) <<< 1;
	assign roll_c = ONE_Q30 - ((TERM_W'(p_xx_s1) + TERM_W'(p_yy_s1)) <<< 1);
	assign clamp  = (pit_s >= ONE_Q30) || (pit_s <= -ONE_Q30);
	assign abs_s  = pit_s[TERM_W-1] ? -pit_s : pit_s;

	always_ff @(posedge clk) begin
		if (en) begin
			terms_s2.yaw_s   <= yaw_s;
			terms_s2.yaw_c   <= yaw_c;
			terms_s2.roll_s  <= roll_s;
			terms_s2.roll_c  <= roll_c;
			terms_s2.pitch_s <= pit_s;
			terms_s2.clamp   <= clamp;
			terms_s2.mag     <= abs_s[MAG_W-1:0];  // only meaningful when not clamped
		end
	end

	assign terms = terms_s2;

endmodule

/* hdl/qte_sqrt.sv */
// ----------------------------------------------------------------------------
// qte_sqrt
// Cosine of pitch: floor(sqrt(1 - s^2)), one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module qte_sqrt import qte_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [MAG_W-1:0]  mag,
	output logic [ROOT_W-1:0] root
);

	logic [2*MAG_W-1:0] sq_s1;
	logic [REM_W-1:0]   v_s [SQ_ITERS+1];
	logic [RES_W-1:0]   r_s [SQ_ITERS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1  <= (2*MAG_W)'(mag) * (2*MAG_W)'(mag);
			v_s[0] <= REM_ONE - REM_W'(sq_s1);
			r_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < SQ_ITERS; k++) begin : g_iter
		localparam logic [RES_W-1:0] BIT = RES_W'(1) << (2 * (SQ_ITERS - 1 - k));
		logic [RES_W-1:0] trial;

		assign trial = r_s[k] + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if (RES_W'(v_s[k]) >= trial) begin
					v_s[k+1] <= v_s[k] - REM_W'(trial);
					r_s[k+1] <= (r_s[k] >> 1) + BIT;
				end else begin
					v_s[k+1] <= v_s[k];
					r_s[k+1] <= r_s[k] >> 1;
				end
			end
		end
	end

	assign root = r_s[SQ_ITERS][ROOT_W-1:0];

endmodule

/* hdl/qte_cordic.sv */
// ----------------------------------------------------------------------------
// qte_cordic
// Unrolled vectoring CORDIC: atan2(y, x) as a 16-bit binary angle.
// ----------------------------------------------------------------------------
module qte_cordic import qte_pkg::*; #(
	parameter int STEPS = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [TERM_W-1:0] y_in,
	input  logic signed [TERM_W-1:0] x_in,
	output logic [15:0]              angle
);

	logic signed [CORD_W-1:0] x_s [STEPS+1];
	logic signed [CORD_W-1:0] y_s [STEPS+1];
	logic signed [ANG_W-1:0]  z_s [STEPS+1];
	logic                     zero_s [STEPS+1];
	logic signed [CORD_W-1:0] xe, ye;
	logic signed [ANG_W-1:0]  zsum;

	assign xe = CORD_W'(x_in);
	assign ye = CORD_W'(y_in);

	// left half-plane folded onto the right by a quarter turn
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			if (xe[CORD_W-1]) begin
				if (!ye[CORD_W-1]) begin
					x_s[0] <= ye;
					y_s[0] <= -xe;
					z_s[0] <= HALF_PI;
				end else begin
					x_s[0] <= -ye;
					y_s[0] <= xe;
					z_s[0] <= -HALF_PI;
				end
			end else begin
				x_s[0] <= xe;
				y_s[0] <= ye;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [CORD_W-1:0] dx, dy;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + ATAN_TAB[i];
				end else begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - ATAN_TAB[i];
				end
			end
		end
	end

	// round to nearest, keep 16 bits: +pi wraps to -32768
	assign zsum  = z_s[STEPS] + ROUND_HALF;
	assign angle = zero_s[STEPS] ? 16'h0000 : zsum[31:16];

endmodule

/* hdl/quaternion_to_euler_angles_top.sv */
// Throughput: one quaternion per cycle; the whole pipeline freezes only while an
// output beat is held by stall, and the output register frees in the same cycle.
// Latency is set by the 33-stage pitch cosine square root (square, subtract,
// 31 bit steps) plus 2 term stages, CORDIC_STEPS + 1 CORDIC stages and the output.
// Reset clears the valid bits only; the pipeline comes up empty.
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top
// Rotation quaternion to ZYX yaw, pitch and roll as binary angles.
// ----------------------------------------------------------------------------
`include "quaternion_to_euler_angles_top_assert.svh"

module quaternion_to_euler_angles_top import qte_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        quat_valid,
	output logic        quat_stall,
	input  quat_beat_t  quat,
	output logic        euler_valid,
	input  logic        euler_stall,
	output euler_beat_t euler
);

	localparam int CORD_LAT = CORDIC_STEPS + 1;
	localparam int PIPE_LAT = TERMS_LAT + SQRT_LAT + CORD_LAT;

	logic                     en;
	logic [PIPE_LAT-1:0]      pipe_vld_s;
	terms_t                   terms;
	terms_t                   terms_dly_s [SQRT_LAT];
	logic [ROOT_W-1:0]        root;
	logic [1:0]               flag_s [CORD_LAT];  // {clamp, positive}
	logic [15:0]              yaw_ang, pit_ang, roll_ang;
	logic signed [TERM_W-1:0] pit_c;
	logic                     euler_valid_q;
	euler_beat_t              euler_q;
	terms_t                   tm;

	assign en         = !(euler_valid_q && euler_stall);
	assign quat_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_vld_s    <= '0;
			euler_valid_q <= 1'b0;
		end else if (en) begin
			pipe_vld_s    <= {pipe_vld_s[PIPE_LAT-2:0], quat_valid};
			euler_valid_q <= pipe_vld_s[PIPE_LAT-1];
		end
	end

	qte_terms u_terms (
		.clk   (clk),
		.en    (en),
		.quat  (quat),
		.terms (terms)
	);

	qte_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.mag  (terms.mag),
		.root (root)
	);

	// terms wait alongside the square root
	always_ff @(posedge clk) begin
		if (en) begin
			terms_dly_s[0] <= terms;
			for (int i = 1; i < SQRT_LAT; i++) begin
				terms_dly_s[i] <= terms_dly_s[i-1];
			end
		end
	end

	assign tm    = terms_dly_s[SQRT_LAT-1];
	assign pit_c = TERM_W'(root);

	qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
		.clk   (clk),
		.en    (en),
		.y_in  (tm.yaw_s),
		.x_in  (tm.yaw_c),
		.angle (yaw_ang)
	);

	qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
		.clk   (clk),
		.en    (en),
		.y_in  (tm.pitch_s),
		.x_in  (pit_c),
		.angle (pit_ang)
	);

	qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
		.clk   (clk),
		.en    (en),
		.y_in  (tm.roll_s),
		.x_in  (tm.roll_c),
		.angle (roll_ang)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			flag_s[0] <= {tm.clamp, !tm.pitch_s[TERM_W-1]};
			for (int i = 1; i < CORD_LAT; i++) begin
				flag_s[i] <= flag_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			euler_q.yaw_angle     <= yaw_ang;
			euler_q.roll_angle    <= roll_ang;
			euler_q.pitch_clamped <= flag_s[CORD_LAT-1][1];
			if (flag_s[CORD_LAT-1][1]) begin
				euler_q.pitch_angle <= flag_s[CORD_LAT-1][0] ? PITCH_POS : PITCH_NEG;
			end else begin
				euler_q.pitch_angle <= pit_ang;
			end
		end
	end

	assign euler_valid = euler_valid_q;
	assign euler       = euler_q;

	`QTE_ASSERT(a_accept_enters, quat_valid && !quat_stall |=> pipe_vld_s[0], "accepted beat lost")
	`QTE_ASSERT(a_freeze, euler_valid && euler_stall |=> $stable(pipe_vld_s), "pipeline moved while held")
	`QTE_ASSERT(a_clamp_angle, euler_valid && euler.pitch_clamped |-> (euler.pitch_angle == PITCH_POS || euler.pitch_angle == PITCH_NEG), "clamped pitch not at quarter turn")
	`QTE_ASSERT_RST(a_rst_empty, !arst_n |=> !euler_valid && pipe_vld_s == '0, "pipeline not empty after reset")

endmodule

/* tb/sv/tb_quaternion_to_euler_angles_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_angles_top
// Drives quaternion beats through the converter under random valid and stall
// gaps, predicts yaw, pitch and roll with a bit-exact CORDIC model or a fixed
// table row and checks every output beat in order against the prediction.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler_angles_top;
	import qte_pkg::*;

	localparam int STEPS      = 16;
	localparam int LATENCY    = STEPS + 37;
	localparam int N_RANDOM   = 1600;
	localparam int CYCLE_CAP  = 400000;
	localparam int HOLD_LEN   = 200;

	typedef struct {
		quat_beat_t  q;
		logic        known;
		euler_beat_t e;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        quat_valid;
	logic        quat_stall;
	quat_beat_t  quat;
	logic        euler_valid;
	logic        euler_stall = 1'b0;
	euler_beat_t euler;

	euler_beat_t angles_due[$];
	int          mismatches = 0;
	int          cycles = 0;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          hold_recv;
	bit          stim_done;

	quaternion_to_euler_angles_top #(.CORDIC_STEPS(STEPS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.quat_valid(quat_valid), .quat_stall(quat_stall), .quat(quat),
		.euler_valid(euler_valid), .euler_stall(euler_stall), .euler(euler)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint shr(longint v, int sh);
		return v >>> sh;
	endfunction

	// angle of (xc, yc), pi = 2^31
	function automatic longint vector_angle(longint ys, longint xs);
		longint xc, yc, za, t, dx, dy;
		xc = xs;
		yc = ys;
		za = 0;
		if (xc == 0 && yc == 0)
			return 0;
		if (xc < 0) begin
			if (yc >= 0) begin
				t = xc; xc = yc; yc = -t; za = longint'(1) << 30;
			end else begin
				t = xc; xc = -yc; yc = t; za = -(longint'(1) << 30);
			end
		end
		for (int i = 0; i < ((STEPS > ATAN_LEN) ? ATAN_LEN : STEPS); i++) begin
			dx = shr(yc, i);
			dy = shr(xc, i);
			if (yc > 0) begin
				xc += dx; yc -= dy; za += longint'(ATAN_TAB[i]);
			end else begin
				xc -= dx; yc += dy; za -= longint'(ATAN_TAB[i]);
			end
		end
		return za;
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic [15:0] bin_angle(longint acc);
		longint r;
		r = (acc + 32768) >>> 16;
		return r[15:0];
	endfunction

	function automatic euler_beat_t zyx_angles(quat_beat_t q);
		longint x, y, z, w, s, one, cpart;
		logic [63:0] rem;
		euler_beat_t e;
		x = q.quat_x; y = q.quat_y; z = q.quat_z; w = q.quat_w;
		one = longint'(1) << 30;
		e.yaw_angle = bin_angle(vector_angle(2 * (x * y + z * w),
			one - 2 * (y * y + z * z)));
		s = 2 * (w * y - x * z);
		if (s >= one) begin
			e.pitch_angle = PITCH_POS;
			e.pitch_clamped = 1'b1;
		end else if (s <= -one) begin
			e.pitch_angle = PITCH_NEG;
			e.pitch_clamped = 1'b1;
		end else begin
			rem = (64'd1 << 60) - 64'(s * s);
			cpart = longint'(floor_sqrt(rem));
			e.pitch_angle = bin_angle(vector_angle(s, cpart));
			e.pitch_clamped = 1'b0;
		end
		e.roll_angle = bin_angle(vector_angle(2 * (w * x + y * z),
			one - 2 * (x * x + y * y)));
		return e;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic quat_beat_t mk(int x, int y, int z, int w);
		quat_beat_t q;
		q.quat_x = x[15:0]; q.quat_y = y[15:0]; q.quat_z = z[15:0]; q.quat_w = w[15:0];
		return q;
	endfunction

	function automatic euler_beat_t ea(int yw, int p, int r, bit c);
		euler_beat_t e;
		e.yaw_angle = yw[15:0]; e.pitch_angle = p[15:0];
		e.roll_angle = r[15:0]; e.pitch_clamped = c;
		return e;
	endfunction

	// one beat offered and accepted, with random idle before it
	task automatic send_beat(quat_beat_t q, euler_beat_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			quat_valid <= 1'b0;
			@(posedge clk);
		end
		quat_valid <= 1'b1;
		quat <= q;
		angles_due.push_back(want);
		@(posedge clk);
		while (quat_stall)
			@(posedge clk);
	endtask

	function automatic quat_beat_t random_quat();
		quat_beat_t q;
		int mode;
		mode = $urandom_range(9);
		q = quat_beat_t'({$urandom, $urandom});
		if (mode < 5) begin
			// components within +/-11585, magnitude at most about 1/sqrt(2)
			q.quat_x = 16'($signed($urandom_range(0, 23170)) - 11585);
			q.quat_y = 16'($signed($urandom_range(0, 23170)) - 11585);
			q.quat_z = 16'($signed($urandom_range(0, 23170)) - 11585);
			q.quat_w = 16'($signed($urandom_range(0, 23170)) - 11585);
		end else if (mode == 5) begin
			// gimbal lock region: w = y, x = -z
			q.quat_y = q.quat_w;
			q.quat_z = -q.quat_x;
		end else if (mode == 6) begin
			q.quat_x = 0;
			q.quat_z = 0;
		end
		return q;
	endfunction

	// output side: stall, compare
	always @(posedge clk) begin
		if (arst_n) begin
			if (euler_valid && !euler_stall) begin
				if (angles_due.size() == 0) begin
					report_mismatch("unexpected beat", 1, 0);
				end else begin
					euler_beat_t w;
					w = angles_due.pop_front();
					if (euler.yaw_angle !== w.yaw_angle)
						report_mismatch("yaw_angle", euler.yaw_angle, w.yaw_angle);
					if (euler.pitch_angle !== w.pitch_angle)
						report_mismatch("pitch_angle", euler.pitch_angle, w.pitch_angle);
					if (euler.roll_angle !== w.roll_angle)
						report_mismatch("roll_angle", euler.roll_angle, w.roll_angle);
					if (euler.pitch_clamped !== w.pitch_clamped)
						report_mismatch("pitch_clamped", euler.pitch_clamped,
							w.pitch_clamped);
				end
			end
			euler_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);
		end
	end

	// long receiver hold-off while the sender keeps offering
	initial begin
		hold_recv = 1'b0;
		wait (cycles == 3000);
		@(posedge clk);
		hold_recv <= 1'b1;
		repeat (HOLD_LEN) @(posedge clk);
		hold_recv <= 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		stim_row_t rows[$];
		stim_row_t r;
		quat_beat_t q;
		stim_done = 0;
		send_idle_pct = 36;
		recv_idle_pct = 70;
		arst_n = 1'b0;
		quat_valid = 1'b0;
		quat = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity, extremes, clamp both ways, non-unit
		rows.push_back('{mk(0, 0, 0, 0), 1, ea(0, 0, 0, 0)});
		rows.push_back('{mk(0, 0, 0, 32767), 1, ea(0, 0, 0, 0)});
		rows.push_back('{mk(0, 16385, 0, 32767), 1, ea(0, 16384, 0, 1)});
		rows.push_back('{mk(0, -16385, 0, 32767), 1, ea(0, -16384, 0, 1)});
		rows.push_back('{mk(-32768, -32768, -32768, -32768), 0, '0});
		rows.push_back('{mk(32767, 32767, 32767, 32767), 0, '0});
		rows.push_back('{mk(32767, -32768, 32767, -32768), 0, '0});
		rows.push_back('{mk(-32768, 0, 0, 0), 0, '0});
		rows.push_back('{mk(0, -32768, 0, 0), 0, '0});
		rows.push_back('{mk(0, 0, -32768, 0), 0, '0});
		rows.push_back('{mk(0, 0, 0, -32768), 0, '0});
		rows.push_back('{mk(32767, 0, 0, 0), 0, '0});
		rows.push_back('{mk(0, 0, 32767, 0), 0, '0});
		rows.push_back('{mk(23170, 0, 0, 23170), 0, '0});
		rows.push_back('{mk(0, 0, 23170, 23170), 0, '0});
		rows.push_back('{mk(0, 23170, 0, 23170), 0, '0});
		rows.push_back('{mk(16384, 16384, 16384, 16384), 0, '0});
		rows.push_back('{mk(1, -1, 1, -1), 0, '0});
		rows.push_back('{mk(100, 200, -300, 400), 0, '0});
		foreach (rows[i]) begin
			r = rows[i];
			send_beat(r.q, r.known ? r.e : zyx_angles(r.q));
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 3) begin
				send_idle_pct = 70;
				recv_idle_pct = 36;
			end else if (n == 2 * N_RANDOM / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (n == N_RANDOM / 2) begin
				// drain pause
				quat_valid <= 1'b0;
				@(posedge clk);
				while (angles_due.size() != 0)
					@(posedge clk);
			end
			q = random_quat();
			send_beat(q, zyx_angles(q));
		end
		quat_valid <= 1'b0;
		while (angles_due.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
